FILE: rtl/clist_pkg.sv
package clist_pkg;

   localparam int REQ_W = 72;
   localparam int RSP_W = 88;

   typedef enum logic [3:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_INSERT     = 4'd1,
      CMD_PUSH_BACK  = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_DELETE     = 4'd4,
      CMD_POP_BACK   = 4'd5,
      CMD_SEARCH     = 4'd6,
      CMD_COUNT      = 4'd7,
      CMD_SUM        = 4'd8,
      CMD_DUMP       = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RK_NONE,
      RK_POS,
      RK_COUNT,
      RK_TOTAL
   } res_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_WALK,
      S_LINK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic         start;
      logic         advance;
      logic         push;
      logic         insert;
      logic         link;
      logic         unlink;
      logic         res_load;
      status_type   res_status;
      res_kind_type res_kind;
      logic         emit_item;
      logic         emit_res;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
      logic    match;
      logic    at_end;
      logic    out_free;
   } stat_type;

endpackage

FILE: rtl/clist_ctrl.sv
module clist_ctrl import clist_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.start = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctl.res_load = 1'b1;
            state_in     = S_EMIT;
            case (stat.cmd) inside
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (stat.full) begin
                     ctl.res_status = ST_FULL;
                  end else begin
                     ctl.push = 1'b1;
                     state_in = S_LINK;
                  end
               end
               CMD_INSERT, CMD_POP_FRONT, CMD_DELETE, CMD_POP_BACK, CMD_SEARCH,
               CMD_SUM, CMD_DUMP: begin
                  if (stat.empty) begin
                     ctl.res_status = ST_EMPTY;
                  end else begin
                     ctl.res_load = 1'b0;
                     state_in     = S_WALK;
                  end
               end
               CMD_COUNT: begin
                  if (stat.empty) begin
                     ctl.res_status = ST_EMPTY;
                  end else begin
                     ctl.res_kind = RK_COUNT;
                  end
               end
               default: ctl.res_status = ST_OK;
            endcase
         end
         S_WALK: begin
            case (stat.cmd)
               CMD_DUMP: begin
                  if (stat.out_free) begin
                     ctl.emit_item = 1'b1;
                     if (stat.at_end) begin
                        state_in = S_IDLE;
                     end else begin
                        ctl.advance = 1'b1;
                     end
                  end
               end
               CMD_SUM: begin
                  if (stat.at_end) begin
                     ctl.res_load = 1'b1;
                     ctl.res_kind = RK_TOTAL;
                     state_in     = S_EMIT;
                  end else begin
                     ctl.advance = 1'b1;
                  end
               end
               default: begin
                  if (stat.match) begin
                     ctl.res_load = 1'b1;
                     state_in     = S_EMIT;
                     if (stat.cmd == CMD_SEARCH) begin
                        ctl.res_kind = RK_POS;
                     end else if (stat.cmd == CMD_INSERT) begin
                        if (stat.full) begin
                           ctl.res_status = ST_FULL;
                        end else begin
                           ctl.insert = 1'b1;
                           state_in   = S_LINK;
                        end
                     end else begin
                        ctl.unlink = 1'b1;
                     end
                  end else if (stat.at_end) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = ST_NOT_FOUND;
                     state_in       = S_EMIT;
                  end else begin
                     ctl.advance = 1'b1;
                  end
               end
            endcase
         end
         S_LINK: begin
            ctl.link = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               ctl.emit_res = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/clist_dp.sv
module clist_dp import clist_pkg::*; #(
   parameter  int CAPACITY = 32,
   localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   input  ctl_type          ctl,
   output stat_type         stat
);

   localparam int PW = (IW > 5) ? IW : 5;
   localparam int QW = (CW > 6) ? CW : 6;

   cmd_type                cmd_ff, cmd_in;
   logic [31:0]            key_ff, key_in, val_ff, val_in;
   logic [IW-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0]          cur_ff, cur_in, prev_ff, prev_in, idx_ff, idx_in;
   logic [IW-1:0]          node_ff, node_in, alloc_ff, alloc_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CAPACITY-1:0]    free_ff, free_in;
   logic [37:0]            sum_ff, sum_in, sum_next;
   status_type             res_status_ff, res_status_in;
   logic [4:0]             res_pos_ff, res_pos_in;
   logic [5:0]             res_count_ff, res_count_in;
   logic [37:0]            res_total_ff, res_total_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [31:0]            val_mem [CAPACITY];
   logic [IW-1:0]          link_mem [CAPACITY];
   logic [31:0]            rd_value;
   logic [IW-1:0]          rd_link;
   logic                   val_we, link_we;
   logic [IW-1:0]          val_waddr, link_waddr, link_wdata;

   logic [IW-1:0]          free_idx;
   logic                   empty, full, at_end;
   logic [PW-1:0]          idx_wide;
   logic [QW-1:0]          count_wide;

   always_comb begin
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(CAPACITY));
   assign at_end     = ((CW + 1)'(idx_ff) + 1'b1) == (CW + 1)'(count_ff);
   assign sum_next   = sum_ff + {{6{rd_value[31]}}, rd_value};
   assign idx_wide   = PW'(idx_ff);
   assign count_wide = QW'(count_ff);

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.empty    = empty;
      stat.full     = full;
      stat.at_end   = at_end;
      stat.out_free = !rsp_valid_ff || rsp_tready;
      case (cmd_ff)
         CMD_POP_FRONT: stat.match = (idx_ff == '0);
         CMD_POP_BACK:  stat.match = at_end;
         default:       stat.match = (rd_value == key_ff);
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      alloc_in      = alloc_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_count_in  = res_count_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;
      val_we        = 1'b0;
      val_waddr     = free_idx;
      link_we       = 1'b0;
      link_waddr    = free_idx;
      link_wdata    = rd_link;

      if (ctl.start) begin
         cmd_in  = cmd_type'(req_tdata[3:0]);
         key_in  = req_tdata[35:4];
         val_in  = req_tdata[67:36];
         cur_in  = head_ff;
         prev_in = tail_ff;
         idx_in  = '0;
         sum_in  = '0;
      end

      if (ctl.advance) begin
         cur_in  = rd_link;
         prev_in = cur_ff;
         idx_in  = idx_ff + 1'b1;
         sum_in  = sum_next;
      end

      if (ctl.push) begin
         val_we            = 1'b1;
         link_we           = 1'b1;
         link_wdata        = empty ? free_idx : head_ff;
         node_in           = empty ? free_idx : tail_ff;
         alloc_in          = free_idx;
         free_in[free_idx] = 1'b0;
         count_in          = count_ff + 1'b1;
         if (empty) begin
            head_in = free_idx;
            tail_in = free_idx;
         end else if (cmd_ff == CMD_PUSH_FRONT) begin
            head_in = free_idx;
         end else begin
            tail_in = free_idx;
         end
      end

      if (ctl.insert) begin
         val_we            = 1'b1;
         link_we           = 1'b1;
         link_wdata        = rd_link;
         node_in           = cur_ff;
         alloc_in          = free_idx;
         free_in[free_idx] = 1'b0;
         count_in          = count_ff + 1'b1;
         if (cur_ff == tail_ff) begin
            tail_in = free_idx;
         end
      end

      // Second half of a push or insert: the predecessor now points at the new node.
      if (ctl.link) begin
         link_we    = 1'b1;
         link_waddr = node_ff;
         link_wdata = alloc_ff;
      end

      if (ctl.unlink) begin
         free_in[cur_ff] = 1'b1;
         if (count_ff <= CW'(1)) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end else begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = rd_link;
            count_in   = count_ff - 1'b1;
            if (cur_ff == head_ff) begin
               head_in = rd_link;
            end
            if (cur_ff == tail_ff) begin
               tail_in = prev_ff;
            end
         end
      end

      if (ctl.res_load) begin
         res_status_in = ctl.res_status;
         res_pos_in    = (ctl.res_kind == RK_POS) ? idx_wide[4:0] : 5'd0;
         res_count_in  = (ctl.res_kind == RK_COUNT) ? count_wide[5:0] : 6'd0;
         res_total_in  = (ctl.res_kind == RK_TOTAL) ? sum_next : 38'd0;
      end

      if (ctl.emit_item) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = at_end;
         rsp_data_in  = RSP_W'({38'd0, 6'd0, 5'd0, rd_value, ST_OK});
      end else if (ctl.emit_res) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_data_in  = RSP_W'({res_total_ff, res_count_ff, res_pos_ff, 32'd0,
                                res_status_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      idx_ff        <= idx_in;
      node_ff       <= node_in;
      alloc_ff      <= alloc_in;
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_count_ff  <= res_count_in;
      res_total_ff  <= res_total_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The read address follows the walk pointer's next value, so the node under
   // cur_ff is always on the read data, also while a stalled dump holds still.
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_ff;
      end
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      rd_value <= val_mem[cur_in];
      rd_link  <= link_mem[cur_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/circular_list_engine_top.sv
// Channel  | Direction | Ports                  | Contents
// req      | in        | req_tvalid/tready/tdata | one command beat
// rsp      | out       | rsp_tvalid/tready/tdata | result beats, tlast on the final one
//
// One command is in work at a time. Push, count and status-only replies need
// no walk; search, delete, insert, pop, sum and dump walk the list one node per
// cycle through the node memory read port, a dump only while the output is free.
// Synchronous active-high reset empties the list; no memory clearing is done.
// A stalled result channel holds a dump walk and the final result beat; a new
// command is taken while the last result still waits in the output register.
module circular_list_engine_top import clist_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // command[3:0], key[35:4], new_value[67:36], zero fill
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[1:0], item_value[33:2], position[38:34], item_count[44:39],
   // total[82:45], zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   ctl_type  ctl;
   stat_type stat;

   clist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   clist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule

FILE: rtl/clist_checker.sv
module clist_checker import clist_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in work");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tlast)
      else $error("error status on a beat that is not last");

   a_dump_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[1:0] == ST_OK && rsp_tdata[82:34] == '0)
      else $error("non-final beat carries more than a dump value");

endmodule

bind circular_list_engine_top clist_checker u_clist_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/tb_circular_list_engine_top.sv
module tb_circular_list_engine_top;
   import clist_pkg::*;

   localparam int CAP = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      status_type      status;
      logic [31:0]     item_value;
      logic [4:0]      position;
      logic [5:0]      item_count;
      logic [37:0]     total;
      logic            last;
   } list_reply_type;

   // Scoreboard: keeps its own copy of the list as a plain ordered array and
   // works out the reply beats for every command beat that is accepted.
   class list_scoreboard;
      logic [31:0] contents[$];
      list_reply_type pending[$];
      int errors;

      function list_reply_type blank(status_type st);
         list_reply_type r;
         r = '0;
         r.status = st;
         r.last = 1'b1;
         return r;
      endfunction

      function int find_first(logic [31:0] key);
         foreach (contents[i])
            if (contents[i] == key) return i;
         return -1;
      endfunction

      function void note_command(cmd_type cmd, logic [31:0] key, logic [31:0] val);
         list_reply_type r;
         int idx;
         logic signed [37:0] acc;
         if (cmd <= CMD_DUMP && cmd != CMD_PUSH_FRONT && cmd != CMD_PUSH_BACK &&
             contents.size() == 0) begin
            pending.push_back(blank(ST_EMPTY));
            return;
         end
         r = blank(ST_OK);
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (contents.size() >= CAP) r.status = ST_FULL;
               else if (cmd == CMD_PUSH_FRONT) contents.push_front(val);
               else contents.push_back(val);
            end
            CMD_INSERT: begin
               idx = find_first(key);
               if (idx < 0) r.status = ST_NOT_FOUND;
               else if (contents.size() >= CAP) r.status = ST_FULL;
               else contents.insert(idx + 1, val);
            end
            CMD_POP_FRONT: void'(contents.pop_front());
            CMD_POP_BACK: void'(contents.pop_back());
            CMD_DELETE: begin
               idx = find_first(key);
               if (idx < 0) r.status = ST_NOT_FOUND;
               else contents.delete(idx);
            end
            CMD_SEARCH: begin
               idx = find_first(key);
               if (idx < 0) r.status = ST_NOT_FOUND;
               else r.position = idx[4:0];
            end
            CMD_COUNT: r.item_count = 6'(contents.size());
            CMD_SUM: begin
               acc = 0;
               foreach (contents[i]) acc += $signed(contents[i]);
               r.total = acc;
            end
            CMD_DUMP: begin
               foreach (contents[i]) begin
                  r = blank(ST_OK);
                  r.item_value = contents[i];
                  r.last = (i == contents.size() - 1);
                  pending.push_back(r);
               end
               return;
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_reply(list_reply_type got);
         list_reply_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected reply beat", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status != want.status) report_mismatch("status", got.status, want.status);
         if (got.item_value != want.item_value)
            report_mismatch("item_value", got.item_value, want.item_value);
         if (got.position != want.position)
            report_mismatch("position", got.position, want.position);
         if (got.item_count != want.item_count)
            report_mismatch("item_count", got.item_count, want.item_count);
         if (got.total != want.total) report_mismatch("total", got.total, want.total);
         if (got.last != want.last) report_mismatch("last", got.last, want.last);
      endfunction

      function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;

   list_scoreboard board = new();
   bit steady = 0;   // no idling on either side while set
   int idle_cycles = 0;

   always #1 clock = ~clock;

   circular_list_engine_top #(.CAPACITY(CAP)) dut (.*);

   // The tlast bit is checked against the last flag that the scoreboard expects.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_reply({rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[38:34],
                               rsp_tdata[44:39], rsp_tdata[82:45], rsp_tlast});
         rsp_tready <= steady || ($urandom_range(99) >= 32);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // The valid line stays up after a beat is taken; it drops only while idling
   // or draining, so it is never written twice at the same edge.
   task automatic send_command(cmd_type cmd, logic [31:0] key, logic [31:0] val);
      while (!steady && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {4'b0, val, key, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_command(cmd, key, val);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   logic [31:0] pick_key;
   int roll;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: every command but push-front on an empty list, extremes, fill to capacity.
      for (int c = 3; c <= 9; c++) send_command(cmd_type'(c), 0, 0);
      send_command(CMD_INSERT, 5, 1);
      send_command(CMD_PUSH_BACK, 0, 32'h7fffffff);
      send_command(CMD_PUSH_FRONT, 0, 32'h80000000);
      send_command(CMD_DELETE, 32'h80000000, 0);   // head by value
      send_command(CMD_DELETE, 32'h7fffffff, 0);   // only element
      send_command(CMD_PUSH_BACK, 0, 7);
      send_command(CMD_INSERT, 7, 9);              // after tail
      send_command(CMD_SEARCH, 9, 0);
      send_command(CMD_SEARCH, 3, 0);
      send_command(CMD_DELETE, 3, 0);
      send_command(CMD_DUMP, 0, 0);
      for (int i = 0; i < 31; i++) send_command(CMD_PUSH_BACK, 0, 32'h7fffffff);
      send_command(CMD_PUSH_FRONT, 0, 1);
      send_command(CMD_INSERT, 7, 1);
      send_command(CMD_SUM, 0, 0);
      send_command(CMD_COUNT, 0, 0);
      send_command(CMD_DUMP, 0, 0);
      for (int i = 0; i < 33; i++) send_command(CMD_PUSH_BACK, 0, 32'h80000000);
      send_command(CMD_SUM, 0, 0);
      wait_drained();
      // Drain the list so the random part starts small.
      for (int i = 0; i < 32; i++) send_command(CMD_POP_BACK, 0, 0);
      send_command(CMD_POP_FRONT, 0, 0);
      wait_drained();
      // Random: small value range so keys often hit stored elements.
      for (int n = 0; n < 180; n++) begin
         steady = (n >= 60 && n < 110);
         if (n == 130) wait_drained();
         roll = $urandom_range(99);
         if (board.contents.size() > 0 && roll < 70)
            pick_key = board.contents[$urandom_range(board.contents.size() - 1)];
         else if (roll < 85) pick_key = $urandom_range(15);
         else pick_key = $urandom;
         send_command(cmd_type'($urandom_range(9)), pick_key,
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(15));
      end
      steady = 0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

FILE: circular_list_engine_top.f
rtl/clist_pkg.sv
rtl/clist_ctrl.sv
rtl/clist_dp.sv
rtl/circular_list_engine_top.sv
rtl/clist_checker.sv
tb/tb_circular_list_engine_top.sv
